@@ hw/rtl/dual_quadrature_knob_display_macros.svh @@
// Assertion macros for the dual quadrature knob display.
// Included by the top level; needs nothing else.
`ifndef DUAL_QUADRATURE_KNOB_DISPLAY_MACROS_SVH
`define DUAL_QUADRATURE_KNOB_DISPLAY_MACROS_SVH

// Same-cycle implication, disabled in reset
`define DQKD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define DQKD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/dqkd_pkg.sv @@
// Shared types, constants and display functions for the knob display.
// No dependencies.
package dqkd_pkg;

  // Click direction codes
  typedef enum logic [1:0] {
    CLICK_NONE = 2'd0,
    CLICK_DOWN = 2'd1,
    CLICK_UP   = 2'd2
  } click_t;

  // One decoded transaction between front and back
  typedef struct packed {
    logic [7:0] knob_value;
    click_t     click_dir;
  } knob_entry_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic not_empty;
    logic not_full;
  } q_status_t;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [2:0] DETENT_RESET = 3'd3;
  localparam logic [7:0] SEG_BLANK    = 8'hFF;

  // Phase bit positions inside the sampled byte
  localparam int ENC0_A_BIT = 0;
  localparam int ENC0_B_BIT = 1;
  localparam int ENC1_A_BIT = 5;
  localparam int ENC1_B_BIT = 6;

  // Active-low seven-segment codes, digits 0..9
  localparam logic [7:0] SEG_CODE [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h98
  };

  function automatic logic [7:0] seg_of(input logic [3:0] digit);
    logic [7:0] code;
    code = SEG_BLANK;
    if (digit < 4'd10) begin
      code = SEG_CODE[digit];
    end
    return code;
  endfunction

  // Split 0..255 into {hundreds, tens, ones}; tens via x*205 >> 11
  function automatic logic [11:0] to_bcd(input logic [7:0] v);
    logic [1:0]  hun;
    logic [7:0]  sub;
    logic [6:0]  rem;
    logic [14:0] prod;
    logic [3:0]  ten;
    logic [6:0]  one;
    hun  = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    sub  = (hun == 2'd2) ? 8'd200 : ((hun == 2'd1) ? 8'd100 : 8'd0);
    rem  = 7'(v - sub);
    prod = 15'(rem) * 15'd205;
    ten  = 4'(prod >> 11);
    one  = rem - 7'(7'(ten) * 7'd10);
    return {2'b00, hun, ten, 4'(one)};
  endfunction

  // Thermometer code with value/32+1 low bits lit
  function automatic logic [7:0] bar_of(input logic [7:0] v);
    return 8'hFF >> (3'd7 - v[7:5]);
  endfunction

endpackage

@@ hw/rtl/dqkd_if.sv @@
// Valid/ready channel interfaces for the knob display.
// Depends on nothing.
interface dqkd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] enc_bits;

  modport source (output valid, output enc_bits, input ready);
  modport sink   (input valid, input enc_bits, output ready);
endinterface

interface dqkd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] knob_value;
  logic [1:0] click_dir;
  logic [7:0] seg_ones;
  logic [7:0] seg_tens;
  logic [7:0] seg_hundreds;
  logic [7:0] bar_pattern;

  modport source (output valid, output knob_value, output click_dir, output seg_ones,
                  output seg_tens, output seg_hundreds, output bar_pattern, input ready);
  modport sink   (input valid, input knob_value, input click_dir, input seg_ones,
                  input seg_tens, input seg_hundreds, input bar_pattern, output ready);
endinterface

@@ hw/rtl/dqkd_fifo.sv @@
// Short queue of decoded transactions between front and back.
// Depends on dqkd_pkg.
module dqkd_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  dqkd_pkg::knob_entry_t push_entry,
  input  logic                 pop,
  output dqkd_pkg::knob_entry_t pop_entry,
  output dqkd_pkg::q_status_t   status
);

  dqkd_pkg::knob_entry_t mem [dqkd_pkg::FIFO_DEPTH];
  logic [dqkd_pkg::FIFO_PTR_W-1:0] wr_ptr;
  logic [dqkd_pkg::FIFO_PTR_W-1:0] rd_ptr;
  logic [dqkd_pkg::FIFO_CNT_W-1:0] count;

  localparam logic [dqkd_pkg::FIFO_PTR_W-1:0] PTR_LAST =
    dqkd_pkg::FIFO_PTR_W'(dqkd_pkg::FIFO_DEPTH - 1);
  localparam logic [dqkd_pkg::FIFO_CNT_W-1:0] CNT_FULL =
    dqkd_pkg::FIFO_CNT_W'(dqkd_pkg::FIFO_DEPTH);

  logic do_push;
  logic do_pop;

  // Status and guarded strobes
  always_comb begin
    status.not_empty = (count != '0);
    status.not_full  = (count != CNT_FULL);
    do_push          = push && status.not_full;
    do_pop           = pop && status.not_empty;
    pop_entry        = mem[rd_ptr];
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/dqkd_front.sv @@
// Front end: takes samples, tracks both encoders' phases and tallies,
// decides clicks and keeps the knob value. Depends on dqkd_pkg, dqkd_if.
module dqkd_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [2:0]            cfg_wr_data,
  dqkd_in_if.sink               knob_in,
  input  dqkd_pkg::q_status_t   q_status,
  output logic                  push,
  output dqkd_pkg::knob_entry_t push_entry
);

  logic              detent_steps;
  logic [2:0]        detent_reg;
  logic              which_encoder;
  logic              last_a [2];
  logic              last_b [2];
  logic signed [3:0] step_tally [2];
  logic [7:0]        knob_level;

  logic              na;
  logic              nb;
  logic              oa;
  logic              ob;
  logic              changed;
  logic              at_detent;
  logic              move_up;
  logic signed [3:0] tally;
  logic signed [3:0] tally_next;
  logic signed [3:0] steps_pos;
  logic signed [3:0] steps_neg;
  dqkd_pkg::click_t  click;
  logic [7:0]        knob_level_next;

  assign detent_steps = (detent_reg != 3'd0);

  // Classify the sample for the encoder being served
  always_comb begin
    na        = which_encoder ? knob_in.enc_bits[dqkd_pkg::ENC1_A_BIT]
                              : knob_in.enc_bits[dqkd_pkg::ENC0_A_BIT];
    nb        = which_encoder ? knob_in.enc_bits[dqkd_pkg::ENC1_B_BIT]
                              : knob_in.enc_bits[dqkd_pkg::ENC0_B_BIT];
    oa        = last_a[which_encoder];
    ob        = last_b[which_encoder];
    tally     = step_tally[which_encoder];
    changed   = (na != oa) || (nb != ob);
    at_detent = na && nb;
    // 01 counts up from A low; 00 and 10 count up from A high
    move_up   = (nb && !na) ? !oa : oa;
    steps_pos = $signed({1'b0, detent_reg});
    steps_neg = -steps_pos;

    click      = dqkd_pkg::CLICK_NONE;
    tally_next = tally;
    if (changed) begin
      if (at_detent) begin
        tally_next = '0;
        if (detent_steps) begin
          if (!oa && (tally == steps_pos)) begin
            click = dqkd_pkg::CLICK_DOWN;
          end else if (oa && (tally == steps_neg)) begin
            click = dqkd_pkg::CLICK_UP;
          end
        end
      end else if (move_up) begin
        if (tally != 4'sd7) begin
          tally_next = tally + 4'sd1;
        end
      end else begin
        if (tally != -4'sd8) begin
          tally_next = tally - 4'sd1;
        end
      end
    end

    case (click)
      dqkd_pkg::CLICK_UP:   knob_level_next = knob_level + 8'd1;
      dqkd_pkg::CLICK_DOWN: knob_level_next = knob_level - 8'd1;
      default:              knob_level_next = knob_level;
    endcase

    knob_in.ready         = q_status.not_full;
    push                  = knob_in.valid && knob_in.ready;
    push_entry.knob_value = knob_level_next;
    push_entry.click_dir  = click;
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      detent_reg <= dqkd_pkg::DETENT_RESET;
    end else if (cfg_wr_en) begin
      detent_reg <= cfg_wr_data;
    end
  end

  // Encoder state, updated per accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      which_encoder <= 1'b0;
      last_a[0]     <= 1'b0;
      last_a[1]     <= 1'b0;
      last_b[0]     <= 1'b0;
      last_b[1]     <= 1'b0;
      step_tally[0] <= '0;
      step_tally[1] <= '0;
      knob_level    <= '0;
    end else if (push) begin
      which_encoder             <= !which_encoder;
      last_a[which_encoder]     <= na;
      last_b[which_encoder]     <= nb;
      step_tally[which_encoder] <= tally_next;
      knob_level                <= knob_level_next;
    end
  end

endmodule

@@ hw/rtl/dqkd_back.sv @@
// Back end: pops decoded transactions, builds digit and bar codes,
// holds them in the output register. Depends on dqkd_pkg, dqkd_if.
module dqkd_back (
  input  logic                  clk,
  input  logic                  rst,
  input  dqkd_pkg::q_status_t   q_status,
  input  dqkd_pkg::knob_entry_t pop_entry,
  output logic                  pop,
  dqkd_out_if.source            knob_out
);

  logic        out_valid;
  logic [7:0]  knob_value;
  logic [1:0]  click_dir;
  logic [7:0]  seg_ones;
  logic [7:0]  seg_tens;
  logic [7:0]  seg_hundreds;
  logic [7:0]  bar_pattern;
  logic [11:0] bcd;
  logic        is_small;
  logic        is_mid;

  // Pop whenever the output register is free or being drained
  always_comb begin
    pop      = q_status.not_empty && (!out_valid || knob_out.ready);
    bcd      = dqkd_pkg::to_bcd(pop_entry.knob_value);
    is_small = (pop_entry.knob_value < 8'd10);
    is_mid   = (pop_entry.knob_value < 8'd100);
  end

  // Output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (knob_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (pop) begin
      knob_value   <= pop_entry.knob_value;
      click_dir    <= 2'(pop_entry.click_dir);
      seg_ones     <= dqkd_pkg::seg_of(bcd[3:0]);
      seg_tens     <= is_small ? dqkd_pkg::SEG_BLANK : dqkd_pkg::seg_of(bcd[7:4]);
      seg_hundreds <= is_mid ? dqkd_pkg::SEG_BLANK : dqkd_pkg::seg_of(bcd[11:8]);
      bar_pattern  <= dqkd_pkg::bar_of(pop_entry.knob_value);
    end
  end

  assign knob_out.valid        = out_valid;
  assign knob_out.knob_value   = knob_value;
  assign knob_out.click_dir    = click_dir;
  assign knob_out.seg_ones     = seg_ones;
  assign knob_out.seg_tens     = seg_tens;
  assign knob_out.seg_hundreds = seg_hundreds;
  assign knob_out.bar_pattern  = bar_pattern;

endmodule

@@ hw/rtl/dual_quadrature_knob_display.sv @@
// Top level of the dual quadrature knob display: front, queue, back.
// Depends on dqkd_pkg, dqkd_if, dqkd_fifo, dqkd_front, dqkd_back and the macro header.
//
//   channel     dir   handshake      payload
//   knob_in     in    valid/ready    enc_bits[7:0]
//   knob_out    out   valid/ready    knob_value, click_dir, seg_ones/tens/hundreds, bar_pattern
//   cfg         in    cfg_wr_en      cfg_wr_data[2:0] (detent_steps)
//
// One sample per cycle while the queue has room; a result passes from front decode
// into the two-entry queue, then into the back's output register.
// The front stalls only when the queue is full; the back drains the queue as the
// output register empties. Synchronous reset clears encoder state, value, queue
// and output valid, and sets detent_steps to 3; no clearing pass.
`include "dual_quadrature_knob_display_macros.svh"

module dual_quadrature_knob_display (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_wr_data,
  dqkd_in_if.sink    knob_in,
  dqkd_out_if.source knob_out
);

  logic                  push;
  logic                  pop;
  dqkd_pkg::knob_entry_t push_entry;
  dqkd_pkg::knob_entry_t pop_entry;
  dqkd_pkg::q_status_t   q_status;

  // Decode samples
  dqkd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .knob_in     (knob_in),
    .q_status    (q_status),
    .push        (push),
    .push_entry  (push_entry)
  );

  // Decoupling queue
  dqkd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .status     (q_status)
  );

  // Display encoding and output register
  dqkd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .pop_entry (pop_entry),
    .pop       (pop),
    .knob_out  (knob_out)
  );

  // Checks
  `DQKD_ASSERT_NOW(a_q_sane, clk, rst, 1'b1, q_status.not_empty || q_status.not_full, "queue both empty and full")
  `DQKD_ASSERT_NOW(a_hold_value, clk, rst, push && $past(push) && !$past(rst) && (push_entry.click_dir == dqkd_pkg::CLICK_NONE), push_entry.knob_value == $past(push_entry.knob_value), "value moved without a click")
  `DQKD_ASSERT_NOW(a_up_value, clk, rst, push && $past(push) && !$past(rst) && (push_entry.click_dir == dqkd_pkg::CLICK_UP), push_entry.knob_value == $past(push_entry.knob_value) + 8'd1, "up click did not increment")
  `DQKD_ASSERT_NEXT(a_pop_fills, clk, rst, pop, knob_out.valid, "popped entry not presented")

endmodule

@@ sim/dqkd_tb_pkg.sv @@
// Readout tracker for the dual quadrature knob display testbench: predicts the
// readout of every accepted sample and checks the readouts in order.
// Depends on dqkd_pkg.
`timescale 1ns / 1ps

package dqkd_tb_pkg;

  // One display readout, as the output channel carries it
  typedef struct packed {
    logic [7:0]       knob_value;
    dqkd_pkg::click_t click_dir;
    logic [7:0]       seg_ones;
    logic [7:0]       seg_tens;
    logic [7:0]       seg_hundreds;
    logic [7:0]       bar_pattern;
  } knob_readout_t;

  class knob_readout_tracker;
    logic [2:0]        detent;
    bit                which;
    logic [1:0]        last_ab [2];   // {A, B} last seen, per encoder
    logic signed [3:0] tally [2];
    logic [7:0]        level;
    knob_readout_t     due_q [$];
    int                errors;
    int                checked;
    int                ups;
    int                downs;
    bit                level_seen [256];

    function new();
      detent = dqkd_pkg::DETENT_RESET;
      which = 1'b0;
      last_ab[0] = 2'b00;
      last_ab[1] = 2'b00;
      tally[0] = '0;
      tally[1] = '0;
      level = 8'd0;
    endfunction

    function void set_detent(input logic [2:0] steps);
      detent = steps;
    endfunction

    function int outstanding();
      return due_q.size();
    endfunction

    function int levels_seen();
      int cnt;
      cnt = 0;
      foreach (level_seen[i]) cnt += level_seen[i];
      return cnt;
    endfunction

    // Active-low segment pattern of one decimal digit
    static function logic [7:0] glyph(input int d);
      case (d)
        0: return 8'hC0;
        1: return 8'hF9;
        2: return 8'hA4;
        3: return 8'hB0;
        4: return 8'h99;
        5: return 8'h92;
        6: return 8'h82;
        7: return 8'hF8;
        8: return 8'h80;
        default: return 8'h98;
      endcase
    endfunction

    // Saturating step of one encoder's tally (-8..7)
    function void nudge(input int e, input bit up);
      if (up) begin
        if (tally[e] != 4'sb0111) tally[e] = tally[e] + 4'sd1;
      end else if (tally[e] != 4'sb1000) begin
        tally[e] = tally[e] - 4'sd1;
      end
    endfunction

    // Predict the readout caused by one accepted sample
    function void take_sample(input logic [7:0] bits);
      knob_readout_t    r;
      logic [1:0]       ab;
      logic             oa;
      int               e;
      int               t;
      int               s;
      int               n;
      dqkd_pkg::click_t dir;
      e = which;
      ab = (e == 0) ? {bits[dqkd_pkg::ENC0_A_BIT], bits[dqkd_pkg::ENC0_B_BIT]} :
                      {bits[dqkd_pkg::ENC1_A_BIT], bits[dqkd_pkg::ENC1_B_BIT]};
      oa = last_ab[e][1];
      dir = dqkd_pkg::CLICK_NONE;
      if (ab != last_ab[e]) begin
        case (ab)
          2'b00, 2'b10: nudge(e, oa);
          2'b01: nudge(e, !oa);
          default: begin
            // detent: a run of exactly the set length clicks
            t = tally[e];
            s = detent;
            if (s != 0 && !oa && t == s) dir = dqkd_pkg::CLICK_DOWN;
            else if (s != 0 && oa && t == -s) dir = dqkd_pkg::CLICK_UP;
            tally[e] = '0;
          end
        endcase
        last_ab[e] = ab;
      end
      which = !which;

      if (dir == dqkd_pkg::CLICK_UP) begin
        level = level + 8'd1;
        ups++;
      end else if (dir == dqkd_pkg::CLICK_DOWN) begin
        level = level - 8'd1;
        downs++;
      end
      level_seen[level] = 1'b1;

      n = level / 32 + 1;
      r.knob_value = level;
      r.click_dir = dir;
      r.seg_ones = glyph(level % 10);
      r.seg_tens = (level < 10) ? dqkd_pkg::SEG_BLANK : glyph((level / 10) % 10);
      r.seg_hundreds = (level < 100) ? dqkd_pkg::SEG_BLANK : glyph((level / 100) % 10);
      r.bar_pattern = 8'((1 << n) - 1);
      due_q.push_back(r);
    endfunction

    function void compare_field(input string tag, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %02h, got %02h", $time, tag, want, got);
      end
    endfunction

    // Check one readout against the oldest prediction
    function void check_readout(input knob_readout_t got);
      knob_readout_t want;
      if (due_q.size() == 0) begin
        errors++;
        $display("%0t: readout with none expected, expected nothing, got value %02h click %0d",
                 $time, got.knob_value, got.click_dir);
        return;
      end
      want = due_q.pop_front();
      checked++;
      compare_field("knob_value", want.knob_value, got.knob_value);
      compare_field("click_dir", 8'(want.click_dir), 8'(got.click_dir));
      compare_field("seg_ones", want.seg_ones, got.seg_ones);
      compare_field("seg_tens", want.seg_tens, got.seg_tens);
      compare_field("seg_hundreds", want.seg_hundreds, got.seg_hundreds);
      compare_field("bar_pattern", want.bar_pattern, got.bar_pattern);
    endfunction
  endclass

endpackage

@@ sim/dual_quadrature_knob_display_tb.sv @@
// Testbench for dual_quadrature_knob_display: detented rotation runs, broken runs
// and noise on both encoders, under random idling, checked against dqkd_tb_pkg.
// Depends on dqkd_pkg, dqkd_if, dqkd_tb_pkg and the RTL.
`timescale 1ns / 1ps

module dual_quadrature_knob_display_tb;

  localparam int ITEMS_PER_PHASE = 105;
  localparam int LIMIT_CYCLES    = 200000;
  localparam int IDLE_PCT        = 21;

  // Phase pairs {A, B} of one encoder
  localparam logic [1:0] PH_LOW    = 2'b00;
  localparam logic [1:0] PH_B      = 2'b01;
  localparam logic [1:0] PH_A      = 2'b10;
  localparam logic [1:0] PH_DETENT = 2'b11;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_wr_en;
  logic [2:0] cfg_wr_data;

  dqkd_in_if  knob_in ();
  dqkd_out_if knob_out ();

  dual_quadrature_knob_display u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .knob_in     (knob_in),
    .knob_out    (knob_out)
  );

  dqkd_tb_pkg::knob_readout_tracker tracker = new();

  logic [1:0] plan0 [$];
  logic [1:0] plan1 [$];
  logic [1:0] last_sent [2];
  bit         next_enc;
  bit         steady;
  int         up_pct;
  logic [2:0] detent_now;
  int         cycle_count;
  int         used_detent [5];

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d readouts still due", cycle_count,
               tracker.outstanding());
      $display("dual_quadrature_knob_display_tb: done, errors");
      $finish;
    end
  end

  // Receiver stalls
  initial begin
    knob_out.ready = 1'b0;
    forever begin
      @(negedge clk);
      knob_out.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Readout monitor
  always @(posedge clk) begin
    dqkd_tb_pkg::knob_readout_t got;
    if (!rst && knob_out.valid && knob_out.ready) begin
      got.knob_value = knob_out.knob_value;
      got.click_dir = dqkd_pkg::click_t'(knob_out.click_dir);
      got.seg_ones = knob_out.seg_ones;
      got.seg_tens = knob_out.seg_tens;
      got.seg_hundreds = knob_out.seg_hundreds;
      got.bar_pattern = knob_out.bar_pattern;
      tracker.check_readout(got);
    end
  end

  // Push a phase, now and then held for one more sample
  function automatic void put_phase(ref logic [1:0] plan [$], input logic [1:0] ph,
                                    input bit stutter);
    plan.push_back(ph);
    if (stutter && $urandom_range(0, 99) < 8) plan.push_back(ph);
  endfunction

  // Rotation run from the detent: 'steps' counted transitions, then back to the detent
  function automatic void add_run(ref logic [1:0] plan [$], input bit up_click,
                                  input int steps, input bit stutter);
    put_phase(plan, PH_DETENT, stutter);
    if (up_click) begin
      // tally goes down to -steps, arrives at the detent from A=1
      if (steps == 1) begin
        put_phase(plan, PH_LOW, stutter);
        put_phase(plan, PH_B, stutter);
        put_phase(plan, PH_A, stutter);
        put_phase(plan, PH_B, stutter);
        put_phase(plan, PH_A, stutter);
      end else begin
        put_phase(plan, PH_B, stutter);
        if (steps % 2 == 1) put_phase(plan, PH_LOW, stutter);
        put_phase(plan, PH_A, stutter);
        for (int i = 0; i < (steps - 2) / 2; i++) begin
          put_phase(plan, PH_B, stutter);
          put_phase(plan, PH_A, stutter);
        end
      end
    end else begin
      // tally goes up to +steps, arrives at the detent from A=0
      if (steps >= 2) put_phase(plan, PH_A, stutter);
      put_phase(plan, PH_LOW, stutter);
      if (steps >= 3) put_phase(plan, PH_B, stutter);
      for (int i = 0; i < steps - 3; i++) begin
        put_phase(plan, PH_A, stutter);
        put_phase(plan, PH_LOW, stutter);
        put_phase(plan, PH_B, stutter);
      end
    end
    put_phase(plan, PH_DETENT, stutter);
  endfunction

  // New plan for an encoder: mostly clean clicks, some wrong counts, holds and noise
  function automatic void refill(ref logic [1:0] plan [$], input int e, input bit may_plan);
    int r;
    r = $urandom_range(0, 99);
    if (!may_plan || (r >= 75 && r < 85)) begin
      repeat ($urandom_range(1, 3)) plan.push_back(last_sent[e]);
    end else if (r < 60) begin
      add_run(plan, $urandom_range(0, 99) < up_pct, detent_now, 1'b1);
    end else if (r < 75) begin
      add_run(plan, $urandom_range(0, 1), $urandom_range(1, 10), 1'b1);
    end else begin
      repeat ($urandom_range(1, 6)) plan.push_back(2'($urandom_range(0, 3)));
    end
  endfunction

  // One transaction on the input channel; starts and ends at a falling edge
  task automatic send_sample(input logic [7:0] bits);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      knob_in.valid <= 1'b0;
      @(negedge clk);
    end
    knob_in.valid <= 1'b1;
    knob_in.enc_bits <= bits;
    @(posedge clk);
    while (!knob_in.ready) @(posedge clk);
    tracker.take_sample(bits);
    @(negedge clk);
  endtask

  // Next sample for the encoder being served; unused bits random or all-equal
  task automatic send_next(input bit may_plan, input bit edge_fill);
    logic [1:0] ph;
    logic [7:0] bits;
    if (next_enc == 1'b0) begin
      if (plan0.size() == 0) refill(plan0, 0, may_plan);
      ph = plan0.pop_front();
    end else begin
      if (plan1.size() == 0) refill(plan1, 1, may_plan);
      ph = plan1.pop_front();
    end
    if (edge_fill) bits = (ph == PH_DETENT) ? 8'hFF : 8'h00;
    else bits = 8'($urandom_range(0, 255));
    if (next_enc == 1'b0) {bits[dqkd_pkg::ENC0_A_BIT], bits[dqkd_pkg::ENC0_B_BIT]} = ph;
    else {bits[dqkd_pkg::ENC1_A_BIT], bits[dqkd_pkg::ENC1_B_BIT]} = ph;
    last_sent[next_enc] = ph;
    send_sample(bits);
    next_enc = !next_enc;
  endtask

  task automatic wait_drained();
    knob_in.valid <= 1'b0;
    while (tracker.outstanding() != 0) @(negedge clk);
  endtask

  // Register write with the block idle
  task automatic write_detent(input logic [2:0] steps);
    wait_drained();
    repeat (4) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= steps;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    tracker.set_detent(steps);
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 3'd0;
    knob_in.valid = 1'b0;
    knob_in.enc_bits = 8'h00;
    last_sent[0] = PH_LOW;
    last_sent[1] = PH_LOW;
    next_enc = 1'b0;
    steady = 1'b0;
    up_pct = 50;
    detent_now = dqkd_pkg::DETENT_RESET;
    cycle_count = 0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: wrap down from 0, wrap up from 255, short odd runs, byte extremes
    add_run(plan0, 1'b0, 3, 1'b0);
    add_run(plan1, 1'b1, 3, 1'b0);
    add_run(plan0, 1'b1, 1, 1'b0);
    add_run(plan1, 1'b0, 2, 1'b0);
    while (plan0.size() != 0 || plan1.size() != 0) send_next(1'b0, 1'b1);

    // Random phases, one detent setting each
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin detent_now = 3'd1; up_pct = 80; end
        1: begin detent_now = 3'd7; up_pct = 50; end
        2: begin detent_now = 3'd2; up_pct = 20; end
        3: begin detent_now = 3'd5; up_pct = 65; end
        default: begin detent_now = 3'($urandom_range(1, 7)); up_pct = 50; end
      endcase
      used_detent[p] = detent_now;
      write_detent(detent_now);
      steady = (p == 1);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // hold off until the pipeline is empty, then resume
        if (p == 2 && k == ITEMS_PER_PHASE / 2) wait_drained();
        send_next(1'b1, 1'b0);
      end
    end
    steady = 1'b0;

    wait_drained();
    repeat (5) @(negedge clk);
    $display("summary: %0d readouts checked, %0d clicks up, %0d clicks down, %0d levels",
             tracker.checked, tracker.ups, tracker.downs, tracker.levels_seen());
    $display("summary: detent settings 3, %0d, %0d, %0d, %0d, %0d; %0d mismatches",
             used_detent[0], used_detent[1], used_detent[2], used_detent[3],
             used_detent[4], tracker.errors);
    if (tracker.errors == 0) begin
      $display("dual_quadrature_knob_display_tb: done, clean");
    end else begin
      $display("dual_quadrature_knob_display_tb: done, errors");
    end
    $finish;
  end

endmodule
